// ===== design/ptd_pkg.sv =====
// Shared types and constants of the periodic task dispatcher.
package ptd_pkg;

  // Width of the configuration write data and of the period arithmetic.
  localparam int unsigned DATA_W = 32;

  // Rows of the task table. Task ids and result ids are five bits wide, so
  // the table cannot grow beyond what those fields can name.
  localparam int unsigned MAX_TASKS = 16;

  // At most this many due tasks are reported for one tick.
  localparam int unsigned MAX_RESULTS = 16;

  // Input item kinds.
  localparam logic [2:0] KIND_REG   = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_CHPER = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;

  // Result status codes.
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_REJ = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TICK_SIZE = 2'd0;
  localparam logic [1:0] CFG_TICK_INC  = 2'd1;
  localparam logic [1:0] CFG_LIMIT     = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  task_id;
    logic [31:0] period;
  } ptd_in_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic       status;
    logic [4:0] result_task;
    logic       last;
  } ptd_out_t;

  // One row of the task table.
  typedef struct packed {
    logic        running;
    logic [31:0] period;
    logic [31:0] elapsed;
  } ptd_entry_t;

  localparam int unsigned ENTRY_W = $bits(ptd_entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_UPD,
    S_RESP,
    S_TDONE
  } state_e;

endpackage

// ===== design/ptd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module ptd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ptd_rem.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module ptd_rem
  import ptd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic              zero_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W + 1);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] dvd_q;
  logic [DATA_W-1:0] div_q;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              take;

  // Shift the next dividend bit into the partial remainder and subtract
  // the divisor whenever it fits.
  always_comb begin
    trial = {rem_q, dvd_q[DATA_W-1]};
    diff  = trial - {1'b0, div_q};
    take  = (trial >= {1'b0, div_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DATA_W);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign zero_o = (rem_q == '0);

endmodule

// ===== design/periodic_task_dispatcher.sv =====
// Top level of the periodic task dispatcher: sequencer, task table and result register.
//
// Items arrive on the input channel (in_valid_i, in_stall_o, in_data_i) and
// results leave on the output channel (out_valid_o, out_stall_i, out_data_o).
// A beat moves on either channel at a rising edge with valid high and stall low.
// The block works on one item at a time: in_stall_o is low only while the
// sequencer is idle. An item rejected on decode goes straight to S_RESP;
// start and stop pass S_RD and S_UPD; register waits in S_DIV and change
// period passes S_DIV, S_RD and S_UPD, S_DIV waiting on the bit-serial
// remainder unit that checks the period against the tick size, one dividend
// bit per cycle. A tick reads (S_RD) and updates (S_UPD) each registered
// task in turn, through the read and write ports of the task table, then
// ends in S_TDONE. Every item gives one result beat, except a tick
// with due tasks, which gives one beat per due task, the final one flagged by
// last. Results go through a single output register, so a new item may be
// accepted while the previous result still waits there. When the receiver
// stalls, the sequencer holds in place until the output register frees.
// Reset clears the task count, the sequencer and the output register and
// loads the configuration defaults; the table itself is not cleared, as only
// entries that have been registered are ever read.
module periodic_task_dispatcher
  import ptd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ptd_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ptd_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

  // Configuration registers.
  logic [31:0] tick_size_q;
  logic [15:0] tick_inc_q;
  logic [4:0]  task_limit_q;

  // Sequencer state and item context.
  state_e           state_q, state_d;
  ptd_in_t          item_q;
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] walk_q;
  logic [4:0]       nres_q;
  logic             pend_valid_q;
  logic [4:0]       pend_id_q;
  logic             resp_status_q;
  logic [4:0]       resp_task_q;

  // Output register.
  logic     out_valid_q;
  ptd_out_t out_q;

  // Combinational decode and datapath.
  logic        in_fire;
  logic        out_free;
  logic [31:0] tick_eff;
  logic        id_ok;
  logic        per_low;
  logic        full;
  logic        go_div;
  logic        go_rd;
  logic        go_tdone;
  logic        rem_start;
  logic        rem_done;
  logic        rem_zero;
  logic [IDX_W-1:0] id_addr;
  ptd_entry_t  rd_entry;
  logic [32:0] sum;
  logic [31:0] e_new;
  logic        due;
  logic        pend_push;
  logic        tick_blocked;
  logic        walk_end;
  logic        reg_write;

  // Memory port signals.
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  ptd_entry_t          ram_wentry;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  // Output load.
  logic     out_load;
  ptd_out_t out_d;

  // ---------------------------------------------------------------------
  // Configuration port.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_size_q  <= 32'd1;
      tick_inc_q   <= 16'd1;
      task_limit_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TICK_SIZE: tick_size_q  <= cfg_data_i;
        CFG_TICK_INC:  tick_inc_q   <= cfg_data_i[15:0];
        CFG_LIMIT:     task_limit_q <= cfg_data_i[4:0];
        default:       ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Item decode at acceptance.
  // ---------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // A zero tick size behaves as a tick size of one.
  assign tick_eff = (tick_size_q == '0) ? 32'd1 : tick_size_q;

  always_comb begin
    id_ok   = (in_data_i.task_id != '0) &&
              (32'(in_data_i.task_id) <= 32'(count_q));
    per_low = (in_data_i.period < tick_eff);
    full    = (32'(count_q) >= 32'(task_limit_q)) || (32'(count_q) >= MAX_TASKS);
    go_div   = 1'b0;
    go_rd    = 1'b0;
    go_tdone = 1'b0;
    case (in_data_i.kind)
      KIND_REG:   go_div = !full && !per_low;
      KIND_START,
      KIND_STOP:  go_rd  = id_ok;
      KIND_CHPER: go_div = id_ok && !per_low;
      KIND_TICK: begin
        go_tdone = (count_q == '0);
        go_rd    = (count_q != '0);
      end
      default:    ;
    endcase
  end

  assign rem_start = in_fire && go_div;

  ptd_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (in_data_i.period),
    .divisor_i  (tick_eff),
    .done_o     (rem_done),
    .zero_o     (rem_zero)
  );

  // ---------------------------------------------------------------------
  // Task table update arithmetic.
  // ---------------------------------------------------------------------
  assign id_addr  = IDX_W'(32'(item_q.task_id) - 32'd1);
  assign rd_entry = ptd_entry_t'(ram_rdata);

  always_comb begin
    // Saturating add of the tick increment to the elapsed count.
    sum          = {1'b0, rd_entry.elapsed} + 33'(tick_inc_q);
    e_new        = sum[32] ? '1 : sum[31:0];
    due          = rd_entry.running && (e_new >= rd_entry.period) &&
                   (nres_q < 5'(MAX_RESULTS));
    pend_push    = due && pend_valid_q;
    tick_blocked = pend_push && !out_free;
    walk_end     = ((32'(walk_q) + 32'd1) >= 32'(count_q));
  end

  assign reg_write = (state_q == S_DIV) && rem_done && rem_zero &&
                     (item_q.kind == KIND_REG);

  // ---------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (go_div) begin
            state_d = S_DIV;
          end else if (go_rd) begin
            state_d = S_RD;
          end else if (go_tdone) begin
            state_d = S_TDONE;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_DIV: begin
        if (rem_done) begin
          if (!rem_zero || (item_q.kind == KIND_REG)) begin
            state_d = S_RESP;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: state_d = S_UPD;
      S_UPD: begin
        if (item_q.kind == KIND_TICK) begin
          if (!tick_blocked) begin
            state_d = walk_end ? S_TDONE : S_RD;
          end
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_TDONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs to the table and the result register.
  // ---------------------------------------------------------------------
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = id_addr;
    ram_wentry = rd_entry;
    ram_re     = (state_q == S_RD);
    ram_raddr  = (item_q.kind == KIND_TICK) ? walk_q : id_addr;
    out_load   = 1'b0;
    out_d      = '{result_kind: item_q.kind, status: resp_status_q,
                   result_task: resp_task_q, last: 1'b1};
    case (state_q)
      S_DIV: begin
        if (reg_write) begin
          ram_we     = 1'b1;
          ram_waddr  = count_q[IDX_W-1:0];
          ram_wentry = '{running: 1'b1, period: item_q.period, elapsed: '0};
        end
      end
      S_UPD: begin
        case (item_q.kind)
          KIND_START,
          KIND_STOP: begin
            ram_we             = 1'b1;
            ram_wentry.running = (item_q.kind == KIND_START);
          end
          KIND_CHPER: begin
            ram_we            = 1'b1;
            ram_wentry.period = item_q.period;
          end
          KIND_TICK: begin
            ram_waddr          = walk_q;
            ram_we             = !tick_blocked;
            ram_wentry.elapsed = due ? '0 : e_new;
            // A newly due task pushes the previously found one out, which
            // is then known not to be the final beat of this tick.
            if (pend_push && !tick_blocked) begin
              out_load = 1'b1;
              out_d    = '{result_kind: KIND_TICK, status: ST_OK,
                           result_task: pend_id_q, last: 1'b0};
            end
          end
          default: ;
        endcase
      end
      S_RESP: out_load = out_free;
      S_TDONE: begin
        out_load = out_free;
        out_d    = '{result_kind: KIND_TICK, status: ST_OK,
                     result_task: pend_valid_q ? pend_id_q : 5'd0, last: 1'b1};
      end
      default: ;
    endcase
  end

  ptd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wentry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (reg_write) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (in_fire) begin
        pend_valid_q <= 1'b0;
      end else if ((state_q == S_UPD) && (item_q.kind == KIND_TICK) &&
                   due && !tick_blocked) begin
        pend_valid_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q        <= in_data_i;
      // Items that go straight to a response are all rejections.
      resp_status_q <= (go_div || go_rd || go_tdone) ? ST_OK : ST_REJ;
      resp_task_q   <= '0;
      walk_q        <= '0;
      nres_q        <= '0;
    end
    if ((state_q == S_DIV) && rem_done) begin
      if (!rem_zero) begin
        resp_status_q <= ST_REJ;
      end else if (item_q.kind == KIND_REG) begin
        resp_task_q <= 5'(32'(count_q) + 32'd1);
      end
    end
    if ((state_q == S_UPD) && (item_q.kind == KIND_TICK) && !tick_blocked) begin
      walk_q <= walk_q + IDX_W'(1);
      if (due) begin
        pend_id_q <= 5'(32'(walk_q) + 32'd1);
        nres_q    <= nres_q + 5'd1;
      end
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // A rejected item never names a task.
  a_rej_no_task : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == ST_REJ)) |-> (out_data_o.result_task == '0))
    else $error("rejected result carries a task id");

  // Only a tick may give more than one beat.
  a_multi_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last) |-> (out_data_o.result_kind == KIND_TICK))
    else $error("non-final beat on a kind other than tick");

  // The table never holds more tasks than it has rows.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MAX_TASKS)
    else $error("task count beyond table depth");

  // The remainder unit only finishes while the sequencer waits for it.
  a_rem_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> (state_q == S_DIV))
    else $error("remainder unit finished outside its wait state");

endmodule
